// ===== design/bdq_pkg.sv =====
// ----------------------------------------------------------------------------
// bdq_pkg
// Shared widths, command codes and status codes of the bounded deque.
// ----------------------------------------------------------------------------
package bdq_pkg;

    localparam int DEPTH_DEFAULT = 64;
    localparam int DATA_W        = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;

    localparam int S_TDATA_W     = 40;   // command + value, padded to bytes
    localparam int M_TDATA_W     = 32;

    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_REVERSE    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

// ===== design/bounded_deque_with_reverse.sv =====
// ----------------------------------------------------------------------------
// bounded_deque_with_reverse
// Double-ended queue of up to DEPTH signed words in a circular buffer RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on s_* carry a command and a value. Commands: push back,
//   push front, pop front, pop back, reverse, dump. Result beats on m_*
//   carry the item, a status (ok, empty, full) in tuser and tlast.
//   Push, pop, reverse and any refused command give one beat with tlast set.
//   Dump gives one beat per element, front to back, tlast on the final one;
//   on an empty deque it gives one empty-status beat.
// Timing and throughput:
//   Push, reverse, refused push, pop on empty, dump on empty: result in the
//   cycle after the input beat; one command per cycle while m_tready is high.
//   Pop: the item passes the RAM read register, then the output register.
//   Dump: RAM read register, then output register; then one beat per cycle
//   while m_tready stays high; s_tready stays low until a pop or dump ends.
// Reset clears the front pointer, count and direction; RAM content is not
// cleared and needs no clearing pass. When m_tready is low the output
// register holds its beat and s_tready drops until the beat can leave.
// ----------------------------------------------------------------------------
module bounded_deque_with_reverse
    import bdq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [2:0] command, [34:3] value

    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] item
    output logic [STATUS_W-1:0]  m_tuser,   // [1:0] status
    output logic                 m_tlast
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W:0]   DEPTH_X = (PTR_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE = PTR_W'(1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;

    // pointer arithmetic modulo DEPTH, both operands below DEPTH
    function automatic logic [PTR_W-1:0] wrap_fwd(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] s;
        logic [PTR_W:0] r;
        s = {1'b0, p} + {1'b0, off};
        r = (s >= DEPTH_X) ? s - DEPTH_X : s;
        return r[PTR_W-1:0];
    endfunction

    function automatic logic [PTR_W-1:0] wrap_bwd(input logic [PTR_W-1:0] p,
                                                  input logic [PTR_W-1:0] off);
        logic [PTR_W:0] r;
        r = (p >= off) ? {1'b0, p} - {1'b0, off}
                       : {1'b0, p} + DEPTH_X - {1'b0, off};
        return r[PTR_W-1:0];
    endfunction

    logic [1:0]          state_reg,      state_next;
    logic [PTR_W-1:0]    front_reg,      front_next;
    logic [CNT_W-1:0]    count_reg,      count_next;
    logic                rev_reg,        rev_next;
    logic [PTR_W-1:0]    dump_ptr_reg,   dump_ptr_next;
    logic [CNT_W-1:0]    dump_left_reg,  dump_left_next;
    logic                out_valid_reg,  out_valid_next;
    logic [DATA_W-1:0]   out_item_reg,   out_item_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic                out_last_reg,   out_last_next;

    logic [CMD_W-1:0]    in_cmd;
    logic [DATA_W-1:0]   in_value;
    logic                in_beat;
    logic                out_free;
    logic                is_empty;
    logic                is_full;
    logic [CNT_W-1:0]    cnt_m1;
    logic [PTR_W-1:0]    back_slot;
    logic [PTR_W-1:0]    next_slot;
    logic [PTR_W-1:0]    second_slot;
    logic [PTR_W-1:0]    front_step;

    logic                ram_wr_en;
    logic [PTR_W-1:0]    ram_wr_addr;
    logic                ram_rd_en;
    logic [PTR_W-1:0]    ram_rd_addr;
    logic [DATA_W-1:0]   ram_rd_data;

    assign in_cmd   = s_tdata[CMD_W-1:0];
    assign in_value = s_tdata[CMD_W+DATA_W-1:CMD_W];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;
    assign in_beat  = s_tvalid && s_tready;

    assign is_empty = (count_reg == '0);
    assign is_full  = (count_reg == CNT_FULL);
    assign cnt_m1   = count_reg - CNT_W'(1);

    // physical slots of the last element, the one past it and the second one
    assign back_slot   = rev_reg ? wrap_bwd(front_reg, cnt_m1[PTR_W-1:0])
                                 : wrap_fwd(front_reg, cnt_m1[PTR_W-1:0]);
    assign next_slot   = rev_reg ? wrap_bwd(front_reg, count_reg[PTR_W-1:0])
                                 : wrap_fwd(front_reg, count_reg[PTR_W-1:0]);
    assign second_slot = rev_reg ? wrap_bwd(front_reg, PTR_ONE)
                                 : wrap_fwd(front_reg, PTR_ONE);
    assign front_step  = rev_reg ? wrap_fwd(front_reg, PTR_ONE)
                                 : wrap_bwd(front_reg, PTR_ONE);

    always_comb begin
        state_next      = state_reg;
        front_next      = front_reg;
        count_next      = count_reg;
        rev_next        = rev_reg;
        dump_ptr_next   = dump_ptr_reg;
        dump_left_next  = dump_left_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_item_next   = out_item_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = next_slot;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = front_reg;

        case (state_reg)
            S_IDLE: begin
                if (in_beat) begin
                    out_item_next   = '0;
                    out_status_next = STATUS_OK;
                    out_last_next   = 1'b1;
                    case (in_cmd)
                        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                            out_valid_next = 1'b1;
                            if (is_full) begin
                                out_status_next = STATUS_FULL;
                            end else begin
                                ram_wr_en  = 1'b1;
                                count_next = count_reg + CNT_W'(1);
                                if (in_cmd == CMD_PUSH_FRONT) begin
                                    ram_wr_addr = front_step;
                                    front_next  = front_step;
                                end
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (is_empty) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                ram_rd_en  = 1'b1;
                                count_next = cnt_m1;
                                state_next = S_POP;
                                if (in_cmd == CMD_POP_FRONT) begin
                                    front_next = second_slot;
                                end else begin
                                    ram_rd_addr = back_slot;
                                end
                            end
                        end
                        CMD_REVERSE: begin
                            out_valid_next = 1'b1;
                            rev_next       = !rev_reg;
                            if (!is_empty) begin
                                front_next = back_slot;
                            end
                        end
                        CMD_DUMP: begin
                            if (is_empty) begin
                                out_valid_next  = 1'b1;
                                out_status_next = STATUS_EMPTY;
                            end else begin
                                ram_rd_en      = 1'b1;
                                dump_ptr_next  = front_reg;
                                dump_left_next = count_reg;
                                state_next     = S_DUMP;
                            end
                        end
                        default: begin
                            // unused command codes: drop the beat
                        end
                    endcase
                end
            end
            S_POP: begin
                // output register is free here: it was draining at acceptance
                out_valid_next  = 1'b1;
                out_item_next   = ram_rd_data;
                out_status_next = STATUS_OK;
                out_last_next   = 1'b1;
                state_next      = S_IDLE;
            end
            S_DUMP: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_item_next   = ram_rd_data;
                    out_status_next = STATUS_OK;
                    out_last_next   = (dump_left_reg == CNT_W'(1));
                    dump_left_next  = dump_left_reg - CNT_W'(1);
                    if (dump_left_reg == CNT_W'(1)) begin
                        state_next = S_IDLE;
                    end else begin
                        // fetch the following element while this one leaves
                        dump_ptr_next = rev_reg ? wrap_bwd(dump_ptr_reg, PTR_ONE)
                                                : wrap_fwd(dump_ptr_reg, PTR_ONE);
                        ram_rd_en     = 1'b1;
                        ram_rd_addr   = dump_ptr_next;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            dump_left_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            front_reg     <= front_next;
            count_reg     <= count_next;
            rev_reg       <= rev_next;
            dump_left_reg <= dump_left_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dump_ptr_reg   <= dump_ptr_next;
        out_item_reg   <= out_item_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

    bdq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH),
        .ADDR_W(PTR_W)
    ) u_store (
        .clk    (aclk),
        .wr_en  (ram_wr_en),
        .wr_addr(ram_wr_addr),
        .wr_data(in_value),
        .rd_en  (ram_rd_en),
        .rd_addr(ram_rd_addr),
        .rd_data(ram_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_item_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

endmodule

// ===== design/bdq_ram.sv =====
// ----------------------------------------------------------------------------
// bdq_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// Read data holds while rd_en is low.
// ----------------------------------------------------------------------------
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded deque with in-place reversal.
// A directed opening walks the empty and reversed corners; a random
// body fills the deque to its bound and mixes every command. A scoreboard
// predicts each response beat and compares item, status and tlast in order.
// ----------------------------------------------------------------------------
module testbench
    import bdq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int RANDOM_CMDS  = 80;
    localparam int IDLE_LIMIT   = 2000;
    localparam int TAIL_CYCLES  = 8;
    localparam int PAD_W        = S_TDATA_W - CMD_W - DATA_W;

    // Codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [DATA_W-1:0] value;
        logic              hold_for_drain;
    } deque_cmd_t;

    typedef struct packed {
        logic [DATA_W-1:0]   item;
        logic [STATUS_W-1:0] status;
        logic                last;
    } deque_resp_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;   // [2:0] command, [34:3] value
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;         // [31:0] item
    logic [STATUS_W-1:0]  m_tuser;         // [1:0] status
    logic                 m_tlast;

    bounded_deque_with_reverse #(.DEPTH(DEPTH)) DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Shadow deque
    logic [DATA_W-1:0] shadow_mem [DEPTH];
    int unsigned       shadow_head = 0;
    int unsigned       shadow_fill = 0;
    bit                shadow_flip = 1'b0;

    deque_cmd_t  cmd_q[$];
    deque_resp_t resp_q[$];

    int unsigned plan_fill    = 0;
    int unsigned planned_cmds = 0;
    int unsigned total_cmds   = 0;
    int unsigned cmds_sent    = 0;
    int unsigned beats_seen   = 0;
    int unsigned full_seen    = 0;
    int unsigned empty_seen   = 0;
    int unsigned drain_holds  = 0;
    int unsigned err_count    = 0;
    int unsigned src_gap      = 0;
    int unsigned sink_gap     = 0;
    int unsigned idle_cycles  = 0;
    int unsigned quiet_left   = 0;
    deque_cmd_t  next_cmd;
    deque_resp_t got_resp;
    deque_resp_t want_resp;

    function automatic int unsigned slot_at(int unsigned idx);
        if (shadow_flip)
            return (shadow_head + DEPTH - (idx % DEPTH)) % DEPTH;
        return (shadow_head + idx) % DEPTH;
    endfunction

    task automatic add_resp(logic [DATA_W-1:0] item, logic [STATUS_W-1:0] status,
                            logic last);
        deque_resp_t r;
        r.item   = item;
        r.status = status;
        r.last   = last;
        resp_q.push_back(r);
    endtask

    // Advance the shadow deque by one command and queue the beats it answers
    task automatic apply_deque_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value);
        logic [DATA_W-1:0] popped;
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (shadow_fill >= DEPTH) begin
                    add_resp('0, STATUS_FULL, 1'b1);
                end else begin
                    if (cmd == CMD_PUSH_BACK) begin
                        shadow_mem[slot_at(shadow_fill)] = value;
                    end else begin
                        shadow_head = shadow_flip ? (shadow_head + 1) % DEPTH
                                                  : (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_mem[shadow_head] = value;
                    end
                    shadow_fill++;
                    add_resp('0, STATUS_OK, 1'b1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (shadow_fill == 0) begin
                    add_resp('0, STATUS_EMPTY, 1'b1);
                end else begin
                    if (cmd == CMD_POP_FRONT) begin
                        popped      = shadow_mem[shadow_head];
                        shadow_head = slot_at(1);
                    end else begin
                        popped = shadow_mem[slot_at(shadow_fill - 1)];
                    end
                    shadow_fill--;
                    add_resp(popped, STATUS_OK, 1'b1);
                end
            end
            CMD_REVERSE: begin
                if (shadow_fill != 0)
                    shadow_head = slot_at(shadow_fill - 1);
                shadow_flip = !shadow_flip;
                add_resp('0, STATUS_OK, 1'b1);
            end
            CMD_DUMP: begin
                if (shadow_fill == 0) begin
                    add_resp('0, STATUS_EMPTY, 1'b1);
                end else begin
                    for (int unsigned i = 0; i < shadow_fill; i++)
                        add_resp(shadow_mem[slot_at(i)], STATUS_OK, i + 1 == shadow_fill);
                end
            end
            default: begin
                // spare codes: no beat, no state change
            end
        endcase
    endtask

    task automatic add_cmd(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] value, bit hold);
        deque_cmd_t c;
        c.cmd            = cmd;
        c.value          = value;
        c.hold_for_drain = hold;
        cmd_q.push_back(c);
        case (cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: if (plan_fill < DEPTH) plan_fill++;
            CMD_POP_FRONT, CMD_POP_BACK:   if (plan_fill > 0) plan_fill--;
            default: ;
        endcase
        if (cmd != CMD_SPARE_A && cmd != CMD_SPARE_B)
            planned_cmds++;
    endtask

    function automatic logic [DATA_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'h0000_0000;
            3:       return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet_left != 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    task automatic flag_mismatch(string msg);
        err_count++;
        if (err_count <= 100)
            $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Stretches with no idling on either side
    always @(posedge aclk) begin
        if (quiet_left != 0)
            quiet_left <= quiet_left - 1;
        else if ($urandom_range(0, 149) == 0)
            quiet_left <= $urandom_range(20, 60);
    end

    // Command driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                apply_deque_cmd(s_tdata[CMD_W-1:0], s_tdata[CMD_W +: DATA_W]);
                cmds_sent++;
            end
            if (s_tvalid && !s_tready) begin
                // hold the beat until it is taken
            end else if (src_gap != 0) begin
                src_gap--;
                s_tvalid <= 1'b0;
            end else if (cmd_q.size() != 0 &&
                         !(cmd_q[0].hold_for_drain && resp_q.size() != 0)) begin
                next_cmd = cmd_q.pop_front();
                if (next_cmd.hold_for_drain)
                    drain_holds++;
                s_tdata  <= {{PAD_W{1'b0}}, next_cmd.value, next_cmd.cmd};
                s_tvalid <= 1'b1;
                src_gap  = pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Response monitor and scoreboard
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                beats_seen++;
                got_resp.item   = m_tdata;
                got_resp.status = m_tuser;
                got_resp.last   = m_tlast;
                if (got_resp.status == STATUS_FULL)
                    full_seen++;
                if (got_resp.status == STATUS_EMPTY)
                    empty_seen++;
                if (resp_q.size() == 0) begin
                    flag_mismatch($sformatf("unexpected beat item=%0d status=%0d last=%0b",
                        $signed(got_resp.item), got_resp.status, got_resp.last));
                end else begin
                    want_resp = resp_q.pop_front();
                    if (got_resp.item !== want_resp.item)
                        flag_mismatch($sformatf("beat %0d item %0d, want %0d", beats_seen,
                            $signed(got_resp.item), $signed(want_resp.item)));
                    if (got_resp.status !== want_resp.status)
                        flag_mismatch($sformatf("beat %0d status %0d, want %0d", beats_seen,
                            got_resp.status, want_resp.status));
                    if (got_resp.last !== want_resp.last)
                        flag_mismatch($sformatf("beat %0d tlast %0b, want %0b", beats_seen,
                            got_resp.last, want_resp.last));
                end
            end
            if (sink_gap != 0) begin
                sink_gap--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    sink_gap = pick_gap();
            end
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout after %0d idle cycles", idle_cycles);
                $display("bounded_deque_with_reverse verification failed");
                $finish;
            end
        end
    end

    initial begin
        int unsigned r;
        bit          filled;

        // Empty deque corners, then extremes through both ends and both directions
        add_cmd(CMD_DUMP,       $urandom, 1'b0);
        add_cmd(CMD_POP_FRONT,  $urandom, 1'b0);
        add_cmd(CMD_POP_BACK,   $urandom, 1'b0);
        add_cmd(CMD_REVERSE,    $urandom, 1'b0);
        add_cmd(CMD_PUSH_BACK,  32'h7fff_ffff, 1'b0);
        add_cmd(CMD_PUSH_FRONT, 32'h8000_0000, 1'b0);
        add_cmd(CMD_PUSH_BACK,  32'h0000_0000, 1'b0);
        add_cmd(CMD_PUSH_FRONT, 32'hffff_ffff, 1'b0);
        add_cmd(CMD_DUMP,       $urandom, 1'b0);
        add_cmd(CMD_REVERSE,    $urandom, 1'b0);
        add_cmd(CMD_DUMP,       $urandom, 1'b0);
        add_cmd(CMD_PUSH_BACK,  32'h5a5a_a5a5, 1'b0);
        add_cmd(CMD_PUSH_FRONT, 32'ha5a5_5a5a, 1'b0);
        add_cmd(CMD_DUMP,       $urandom, 1'b0);
        add_cmd(CMD_POP_FRONT,  $urandom, 1'b0);
        add_cmd(CMD_POP_BACK,   $urandom, 1'b0);
        add_cmd(CMD_SPARE_A,    $urandom, 1'b0);
        add_cmd(CMD_SPARE_B,    $urandom, 1'b0);
        add_cmd(CMD_REVERSE,    $urandom, 1'b0);
        add_cmd(CMD_POP_FRONT,  $urandom, 1'b0);
        add_cmd(CMD_POP_BACK,   $urandom, 1'b0);
        add_cmd(CMD_POP_FRONT,  $urandom, 1'b0);
        add_cmd(CMD_POP_BACK,   $urandom, 1'b0);
        add_cmd(CMD_DUMP,       $urandom, 1'b0);

        // Random body; the first random command waits for the deque to go quiet
        filled = 1'b0;
        r = planned_cmds + RANDOM_CMDS;
        add_cmd(CMD_DUMP, $urandom, 1'b1);
        while (planned_cmds < r) begin
            if (!filled && planned_cmds >= 35) begin
                // fill to the bound, then hit full from both ends
                while (plan_fill < DEPTH)
                    add_cmd($urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
                            rand_word(), 1'b0);
                add_cmd(CMD_PUSH_FRONT, rand_word(), 1'b0);
                add_cmd(CMD_PUSH_BACK,  rand_word(), 1'b0);
                add_cmd(CMD_DUMP,       $urandom, 1'b0);
                add_cmd(CMD_REVERSE,    $urandom, 1'b0);
                add_cmd(CMD_DUMP,       $urandom, 1'b1);
                filled = 1'b1;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:23]:  add_cmd(CMD_PUSH_BACK,  rand_word(), 1'b0);
                    [24:43]: add_cmd(CMD_PUSH_FRONT, rand_word(), 1'b0);
                    [44:59]: add_cmd(CMD_POP_FRONT,  $urandom, 1'b0);
                    [60:75]: add_cmd(CMD_POP_BACK,   $urandom, 1'b0);
                    [76:85]: add_cmd(CMD_REVERSE,    $urandom, 1'b0);
                    [86:93]: add_cmd(CMD_DUMP,       $urandom, $urandom_range(0, 3) == 0);
                    default: add_cmd($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                                     $urandom, 1'b0);
                endcase
            end
        end
        total_cmds = cmd_q.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (cmds_sent < total_cmds) @(posedge aclk);
        while (resp_q.size() != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Covered %0d commands (deque filled to %0d, both ends, both directions),",
                 cmds_sent, DEPTH);
        $display("checked %0d response beats: %0d full, %0d empty, %0d drain holds",
                 beats_seen, full_seen, empty_seen, drain_holds);
        if (err_count == 0) begin
            $display("bounded_deque_with_reverse verification clean");
        end else begin
            $display("%0d mismatches", err_count);
            $display("bounded_deque_with_reverse verification failed");
        end
        $finish;
    end

endmodule
